>>> src/priority_periodic_task_scheduler_core_defines.svh
// Assertion macros shared by the scheduler top level.
`ifndef PRIORITY_PERIODIC_TASK_SCHEDULER_CORE_DEFINES_SVH
`define PRIORITY_PERIODIC_TASK_SCHEDULER_CORE_DEFINES_SVH

// Same-cycle implication, sampled on clk and disabled during reset.
`define PTS_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk and disabled during reset.
`define PTS_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> src/pts_pkg.sv
// Shared types and constants of the priority periodic task scheduler.
`timescale 1ns / 1ps
package pts_pkg;

	// Operation codes carried by an input item.
	localparam logic [2:0] FN_INIT     = 3'd0;
	localparam logic [2:0] FN_TICK     = 3'd1;
	localparam logic [2:0] FN_DISPATCH = 3'd2;
	localparam logic [2:0] FN_FINISH   = 3'd3;
	localparam logic [2:0] FN_TRIGGER  = 3'd4;
	localparam logic [2:0] FN_CLEAR    = 3'd5;

	// Configuration register indexes.
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 64;
	localparam logic [CFG_IDX_W-1:0] CFG_TASK_COUNT   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_PERIODS_LOW  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_PERIODS_HIGH = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_PRIORITIES   = 2'd3;

	localparam int TOTAL_W = 19;
	localparam logic [7:0]  PRIO_NEVER  = 8'hFF;
	localparam logic [15:0] OVERRUN_MAX = 16'hFFFF;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic start;
		logic step;
		logic commit;
		logic load;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic last_slot;
	} sts_t;

endpackage

>>> src/priority_periodic_task_scheduler_core.sv
// Top level of the priority periodic task scheduler.
// Each accepted item is worked by walking the task slots one per clock through a single
// access to the countdown and overrun registers: the block takes the item, walks every
// slot, then commits the dispatch or running-task change and then loads the result
// register once that register is empty or being emptied; a new item is accepted only
// after the last one has been loaded into it. The result register holds a finished item
// while the next one is taken in; configuration writes take effect at once and should be
// made only while no item is in flight.
`timescale 1ns / 1ps
`include "priority_periodic_task_scheduler_core_defines.svh"
module priority_periodic_task_scheduler_core #(
	parameter int MAX_TASKS = 8
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [pts_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [pts_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic [2:0]                      func,
	input  logic [2:0]                      task_index,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic                            dispatched,
	output logic [2:0]                      dispatched_task,
	output logic                            busy_res,
	output logic [7:0]                      ready_mask,
	output logic [pts_pkg::TOTAL_W-1:0]     total_overrun
);
	import pts_pkg::*;

	cmd_t cmd;
	sts_t sts;

	// Sequencer.
	pts_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	// Task state and result.
	pts_datapath #(
		.MAX_TASKS (MAX_TASKS)
	) u_datapath (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_we          (cfg_we),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.func            (func),
		.task_index      (task_index),
		.cmd             (cmd),
		.sts             (sts),
		.dispatched      (dispatched),
		.dispatched_task (dispatched_task),
		.busy_res        (busy_res),
		.ready_mask      (ready_mask),
		.total_overrun   (total_overrun)
	);

	// An accepted item keeps the input closed while it is being worked.
	`PTS_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready, "input open during walk")
	// A dispatch result always shows a running task.
	`PTS_ASSERT_NOW(a_dispatch_busy, out_valid && dispatched, busy_res, "dispatch without running task")
	// The dispatched task no longer shows as ready.
	`PTS_ASSERT_NOW(a_dispatch_clears, out_valid && dispatched, !ready_mask[dispatched_task], "dispatched task still ready")

endmodule

>>> src/pts_ctrl.sv
// Controller state machine of the scheduler: sequences accept, slot walk, commit and result.
`timescale 1ns / 1ps
module pts_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	output logic          out_valid,
	input  logic          out_ready,
	input  pts_pkg::sts_t sts,
	output pts_pkg::cmd_t cmd
);
	import pts_pkg::*;

	typedef enum logic [3:0] {
		ST_IDLE   = 4'b0001,
		ST_WALK   = 4'b0010,
		ST_COMMIT = 4'b0100,
		ST_RESULT = 4'b1000
	} state_t;

	state_t state_q, state_d;
	logic   out_valid_q;
	logic   load;

	// The result register is loaded once it is empty or being emptied.
	assign load = (state_q == ST_RESULT) && (!out_valid_q || out_ready);

	assign in_ready   = (state_q == ST_IDLE);
	assign out_valid  = out_valid_q;
	assign cmd.start  = (state_q == ST_IDLE) && in_valid;
	assign cmd.step   = (state_q == ST_WALK);
	assign cmd.commit = (state_q == ST_COMMIT);
	assign cmd.load   = load;

	// Next-state logic.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) state_d = ST_WALK;
			end
			ST_WALK: begin
				if (sts.last_slot) state_d = ST_COMMIT;
			end
			ST_COMMIT: begin
				state_d = ST_RESULT;
			end
			ST_RESULT: begin
				if (load) state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// State and result valid registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

>>> src/pts_datapath.sv
// Datapath of the scheduler: configuration, per-slot task state, slot walk and result register.
`timescale 1ns / 1ps
module pts_datapath #(
	parameter int MAX_TASKS = 8
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [pts_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [pts_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  logic [2:0]                      func,
	input  logic [2:0]                      task_index,
	input  pts_pkg::cmd_t                   cmd,
	output pts_pkg::sts_t                   sts,
	output logic                            dispatched,
	output logic [2:0]                      dispatched_task,
	output logic                            busy_res,
	output logic [7:0]                      ready_mask,
	output logic [pts_pkg::TOTAL_W-1:0]     total_overrun
);
	import pts_pkg::*;

	localparam int IDX_W = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
	localparam logic [3:0] MAX_N = 4'(MAX_TASKS);
	localparam logic [IDX_W-1:0] LAST_SLOT = IDX_W'(MAX_TASKS - 1);

	// Configuration registers.
	logic [3:0]   task_count_q;
	logic [63:0]  periods_low_q;
	logic [63:0]  periods_high_q;
	logic [63:0]  priorities_q;

	// Task state.
	logic [15:0]          cd_q [MAX_TASKS];
	logic [15:0]          ov_q [MAX_TASKS];
	logic [MAX_TASKS-1:0] ready_q;
	logic                 running_q;
	logic [IDX_W-1:0]     running_task_q;

	// Per-item working registers.
	logic [2:0]         func_q;
	logic [2:0]         idx_q;
	logic [IDX_W-1:0]   slot_q;
	logic [7:0]         lead_prio_q;
	logic [IDX_W-1:0]   best_q;
	logic               found_q;
	logic               disp_q;
	logic [TOTAL_W-1:0] total_q;

	// Result register.
	logic               dispatched_q;
	logic [2:0]         dispatched_task_q;
	logic               busy_res_q;
	logic [7:0]         ready_mask_q;
	logic [TOTAL_W-1:0] total_overrun_q;

	// Slot-walk signals.
	logic [3:0]           n_eff;
	logic [MAX_TASKS-1:0] in_use_vec;
	logic [2:0]           slot3;
	logic [127:0]         periods_all;
	logic [15:0]          period;
	logic [7:0]           prio;
	logic                 in_use;
	logic                 running_here;
	logic [15:0]          cd_dec;
	logic [15:0]          cd_nxt;
	logic [15:0]          ov_nxt;
	logic                 rdy_nxt;
	logic                 take_best;

	// Slots in use, limited to the number of slots built.
	assign n_eff = (task_count_q > MAX_N) ? MAX_N : task_count_q;

	always_comb begin
		for (int j = 0; j < MAX_TASKS; j++) begin
			in_use_vec[j] = (4'(j) < n_eff);
		end
	end

	assign slot3        = 3'(slot_q);
	assign periods_all  = {periods_high_q, periods_low_q};
	assign period       = periods_all[{slot3, 4'b0000} +: 16];
	assign prio         = priorities_q[{slot3, 3'b000} +: 8];
	assign in_use       = in_use_vec[slot_q];
	assign running_here = running_q && (running_task_q == slot_q);
	assign cd_dec       = cd_q[slot_q] - 16'd1;
	assign sts.last_slot = (slot_q == LAST_SLOT);

	// Work on the current slot for the latched operation.
	always_comb begin
		cd_nxt    = cd_q[slot_q];
		ov_nxt    = ov_q[slot_q];
		rdy_nxt   = ready_q[slot_q];
		take_best = 1'b0;
		unique case (func_q)
			FN_INIT: begin
				cd_nxt  = period;
				ov_nxt  = 16'd0;
				rdy_nxt = 1'b0;
			end
			FN_TICK: begin
				if (in_use && (period != 16'd0)) begin
					cd_nxt = cd_dec;
					if (cd_dec == 16'd0) begin
						cd_nxt = period;
						if (ready_q[slot_q] || running_here) begin
							if (ov_q[slot_q] != OVERRUN_MAX) ov_nxt = ov_q[slot_q] + 16'd1;
						end else begin
							rdy_nxt = 1'b1;
						end
					end
				end
			end
			FN_DISPATCH: begin
				take_best = in_use && ready_q[slot_q] && (prio < lead_prio_q);
			end
			FN_TRIGGER: begin
				if (in_use && (idx_q == slot3)) rdy_nxt = 1'b1;
			end
			FN_CLEAR: begin
				if (in_use) ov_nxt = 16'd0;
			end
			default: begin
				cd_nxt = cd_q[slot_q];
			end
		endcase
	end

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			task_count_q   <= 4'd0;
			periods_low_q  <= 64'd0;
			periods_high_q <= 64'd0;
			priorities_q   <= 64'd0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_TASK_COUNT:   task_count_q   <= cfg_data[3:0];
				CFG_PERIODS_LOW:  periods_low_q  <= cfg_data;
				CFG_PERIODS_HIGH: periods_high_q <= cfg_data;
				CFG_PRIORITIES:   priorities_q   <= cfg_data;
				default:          task_count_q   <= task_count_q;
			endcase
		end
	end

	// Task state: slot updates during the walk, running task at commit.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int j = 0; j < MAX_TASKS; j++) begin
				cd_q[j] <= 16'd0;
				ov_q[j] <= 16'd0;
			end
			ready_q        <= '0;
			running_q      <= 1'b0;
			running_task_q <= '0;
		end else if (cmd.step) begin
			cd_q[slot_q]    <= cd_nxt;
			ov_q[slot_q]    <= ov_nxt;
			ready_q[slot_q] <= rdy_nxt;
		end else if (cmd.commit) begin
			if ((func_q == FN_DISPATCH) && !running_q && found_q) begin
				ready_q[best_q] <= 1'b0;
				running_q       <= 1'b1;
				running_task_q  <= best_q;
			end else if ((func_q == FN_INIT) || (func_q == FN_FINISH)) begin
				running_q      <= 1'b0;
				running_task_q <= '0;
			end
		end
	end

	// Per-item control: slot counter, dispatch search and dispatch flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_q      <= '0;
			found_q     <= 1'b0;
			disp_q      <= 1'b0;
			lead_prio_q <= PRIO_NEVER;
		end else if (cmd.start) begin
			slot_q      <= '0;
			found_q     <= 1'b0;
			disp_q      <= 1'b0;
			lead_prio_q <= PRIO_NEVER;
		end else if (cmd.step) begin
			if (!sts.last_slot) slot_q <= slot_q + IDX_W'(1);
			if (take_best) begin
				lead_prio_q <= prio;
				found_q     <= 1'b1;
			end
		end else if (cmd.commit) begin
			disp_q <= (func_q == FN_DISPATCH) && !running_q && found_q;
		end
	end

	// Item fields, best slot and running overrun total.
	always_ff @(posedge clk) begin
		if (cmd.start) begin
			func_q  <= func;
			idx_q   <= task_index;
			best_q  <= '0;
			total_q <= '0;
		end else if (cmd.step) begin
			if (take_best) best_q <= slot_q;
			if (in_use) total_q <= total_q + TOTAL_W'(ov_nxt);
		end
	end

	// Result register.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			dispatched_q      <= disp_q;
			dispatched_task_q <= disp_q ? 3'(best_q) : 3'd0;
			busy_res_q        <= running_q;
			ready_mask_q      <= 8'(ready_q & in_use_vec);
			total_overrun_q   <= total_q;
		end
	end

	assign dispatched      = dispatched_q;
	assign dispatched_task = dispatched_task_q;
	assign busy_res        = busy_res_q;
	assign ready_mask      = ready_mask_q;
	assign total_overrun   = total_overrun_q;

endmodule

>>> tb/sv/tb_priority_periodic_task_scheduler_core.sv
// Self-checking testbench for the priority periodic task scheduler core.
`timescale 1ns / 1ps
module tb_priority_periodic_task_scheduler_core;
	import pts_pkg::*;

	localparam int MAX_TASKS = 8;
	localparam int SETTLE_CYCLES = 2 * (MAX_TASKS + 3);
	localparam int HOLD_CYCLES = 400;
	localparam int FINAL_TICKS = 24;

	// Operation codes the block does not use; they must only report status.
	localparam logic [2:0] FN_SPARE6 = 3'd6;
	localparam logic [2:0] FN_SPARE7 = 3'd7;

	// Status reported by one result item.
	typedef struct packed {
		logic                disp;
		logic [2:0]          disp_slot;
		logic                busy;
		logic [7:0]          mask;
		logic [TOTAL_W-1:0]  total;
	} sched_status_t;

	// Scheduler state mirror: predicts the status of every accepted item and
	// compares the block's results with the oldest prediction.
	class sched_scoreboard;
		logic [3:0]     slot_count_reg;
		logic [63:0]    periods_lo;
		logic [63:0]    periods_hi;
		logic [63:0]    prio_word;
		logic [15:0]    count_down[MAX_TASKS];
		bit             ready_bit[MAX_TASKS];
		logic [15:0]    overrun_cnt[MAX_TASKS];
		bit             run_active;
		logic [2:0]     run_slot;
		sched_status_t  status_due_q[$];
		int             fails;

		function new();
			slot_count_reg = '0;
			periods_lo = '0;
			periods_hi = '0;
			prio_word = '0;
			for (int i = 0; i < MAX_TASKS; i++) begin
				count_down[i] = '0;
				ready_bit[i] = 0;
				overrun_cnt[i] = '0;
			end
			run_active = 0;
			run_slot = '0;
			fails = 0;
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
			case (idx)
				CFG_TASK_COUNT:   slot_count_reg = data[3:0];
				CFG_PERIODS_LOW:  periods_lo = data;
				CFG_PERIODS_HIGH: periods_hi = data;
				CFG_PRIORITIES:   prio_word = data;
				default: ;
			endcase
		endfunction

		function int slots_active();
			return (slot_count_reg > MAX_TASKS) ? MAX_TASKS : int'(slot_count_reg);
		endfunction

		function logic [15:0] period_of(int i);
			return (i < 4) ? periods_lo[16*i +: 16] : periods_hi[16*(i-4) +: 16];
		endfunction

		// Advances the mirror by one accepted item and queues its status.
		function void note_item(logic [2:0] fn, logic [2:0] idx);
			int n;
			int best;
			bit found;
			logic [7:0] lead_prio;
			logic [15:0] p;
			sched_status_t st;
			n = slots_active();
			st = '0;
			case (fn)
				FN_INIT: begin
					for (int i = 0; i < MAX_TASKS; i++) begin
						count_down[i] = period_of(i);
						ready_bit[i] = 0;
						overrun_cnt[i] = '0;
					end
					run_active = 0;
					run_slot = '0;
				end
				FN_TICK: begin
					for (int i = 0; i < n; i++) begin
						p = period_of(i);
						if (p != 16'd0) begin
							count_down[i] = count_down[i] - 16'd1;
							if (count_down[i] == 16'd0) begin
								count_down[i] = p;
								if (ready_bit[i] || (run_active && run_slot == i)) begin
									if (overrun_cnt[i] != OVERRUN_MAX)
										overrun_cnt[i] = overrun_cnt[i] + 16'd1;
								end else begin
									ready_bit[i] = 1;
								end
							end
						end
					end
				end
				FN_DISPATCH: begin
					if (!run_active) begin
						found = 0;
						best = 0;
						lead_prio = PRIO_NEVER;
						for (int i = 0; i < n; i++) begin
							if (ready_bit[i] && prio_word[8*i +: 8] < lead_prio) begin
								lead_prio = prio_word[8*i +: 8];
								best = i;
								found = 1;
							end
						end
						if (found) begin
							ready_bit[best] = 0;
							run_active = 1;
							run_slot = 3'(best);
							st.disp = 1'b1;
							st.disp_slot = 3'(best);
						end
					end
				end
				FN_FINISH: begin
					run_active = 0;
					run_slot = '0;
				end
				FN_TRIGGER: begin
					if (int'(idx) < n)
						ready_bit[idx] = 1;
				end
				FN_CLEAR: begin
					for (int i = 0; i < n; i++)
						overrun_cnt[i] = '0;
				end
				default: ;
			endcase
			for (int i = 0; i < n; i++) begin
				st.mask[i] = ready_bit[i];
				st.total = st.total + {3'b000, overrun_cnt[i]};
			end
			st.busy = run_active;
			status_due_q.push_back(st);
		endfunction

		// Compares one accepted result item with the oldest prediction.
		function void check_result(sched_status_t got);
			sched_status_t want;
			if (status_due_q.size() == 0) begin
				$error("result item arrived with no status expected");
				fails++;
				return;
			end
			want = status_due_q.pop_front();
			if (got.disp !== want.disp) begin
				$error("dispatched: expected %0d, actual %0d", want.disp, got.disp);
				fails++;
			end
			if (got.disp_slot !== want.disp_slot) begin
				$error("dispatched_task: expected %0d, actual %0d", want.disp_slot, got.disp_slot);
				fails++;
			end
			if (got.busy !== want.busy) begin
				$error("busy_res: expected %0d, actual %0d", want.busy, got.busy);
				fails++;
			end
			if (got.mask !== want.mask) begin
				$error("ready_mask: expected 0x%02h, actual 0x%02h", want.mask, got.mask);
				fails++;
			end
			if (got.total !== want.total) begin
				$error("total_overrun: expected %0d, actual %0d", want.total, got.total);
				fails++;
			end
		endfunction
	endclass

	logic                   clk;
	logic                   arst_n;
	logic                   cfg_we;
	logic [CFG_IDX_W-1:0]   cfg_index;
	logic [CFG_DATA_W-1:0]  cfg_data;
	logic                   in_valid;
	logic                   in_ready;
	logic [2:0]             func;
	logic [2:0]             task_index;
	logic                   out_valid;
	logic                   out_ready;
	logic                   dispatched;
	logic [2:0]             dispatched_task;
	logic                   busy_res;
	logic [7:0]             ready_mask;
	logic [TOTAL_W-1:0]     total_overrun;

	sched_scoreboard sb;
	bit idle_on;
	int hold_left;

	priority_periodic_task_scheduler_core #(
		.MAX_TASKS(MAX_TASKS)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.func(func),
		.task_index(task_index),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.dispatched(dispatched),
		.dispatched_task(dispatched_task),
		.busy_res(busy_res),
		.ready_mask(ready_mask),
		.total_overrun(total_overrun)
	);

	// Clock generation.
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Overall time limit for the run.
	initial begin
		#40000000;
		$display("priority_periodic_task_scheduler_core test failed");
		$finish;
	end

	// Result side: random stalls, one long hold-off on request, checks at the edge.
	initial begin : result_sink
		int stall_left;
		bit ready_now;
		stall_left = 0;
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			ready_now = arst_n;
			if (hold_left > 0) begin
				ready_now = 1'b0;
				hold_left--;
			end else if (stall_left > 0) begin
				ready_now = 1'b0;
				stall_left--;
			end else if (idle_on && $urandom_range(0, 7) == 0) begin
				ready_now = 1'b0;
				stall_left = $urandom_range(1, 9) - 1;
			end
			out_ready <= ready_now;
			@(posedge clk);
			if (out_valid && out_ready)
				sb.check_result({dispatched, dispatched_task, busy_res, ready_mask,
					total_overrun});
		end
	end

	// Offers one item and waits for it to be accepted, then maybe idles.
	task automatic send_item(logic [2:0] fn, logic [2:0] idx);
		int gap;
		@(negedge clk);
		in_valid <= 1'b1;
		func <= fn;
		task_index <= idx;
		do @(posedge clk); while (!in_ready);
		sb.note_item(fn, idx);
		if (idle_on && $urandom_range(0, 5) == 0) begin
			gap = $urandom_range(1, 9);
			@(negedge clk);
			in_valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
	endtask

	// Stops offering items and waits until the block is idle.
	task automatic settle();
		@(negedge clk);
		in_valid <= 1'b0;
		while (sb.status_due_q.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(negedge clk);
		cfg_we <= 1'b0;
		sb.write_reg(idx, data);
	endtask

	// Mostly short periods so that countdowns expire often.
	function automatic logic [15:0] rand_period();
		int r;
		r = $urandom_range(0, 19);
		if (r < 2)
			return 16'd0;
		else if (r < 16)
			return 16'($urandom_range(1, 6));
		else if (r == 16)
			return 16'hFFFF;
		else if (r == 17)
			return 16'd1;
		return 16'($urandom_range(7, 40));
	endfunction

	// Priorities crowd into a few values so that ties are common.
	function automatic logic [7:0] rand_prio();
		int r;
		r = $urandom_range(0, 9);
		if (r < 2)
			return PRIO_NEVER;
		else if (r < 7)
			return 8'($urandom_range(0, 3));
		else if (r == 7)
			return 8'd0;
		return 8'($urandom_range(0, 254));
	endfunction

	function automatic logic [2:0] rand_func();
		int r;
		r = $urandom_range(0, 99);
		if (r < 35)
			return FN_TICK;
		else if (r < 55)
			return FN_DISPATCH;
		else if (r < 70)
			return FN_FINISH;
		else if (r < 85)
			return FN_TRIGGER;
		else if (r < 90)
			return FN_CLEAR;
		else if (r < 94)
			return FN_INIT;
		else if (r < 97)
			return FN_SPARE6;
		return FN_SPARE7;
	endfunction

	// Main sequence: reset, directed items, random phases, closing run.
	initial begin : stimulus
		logic [63:0] plo, phi, prw;
		logic [3:0] cnt;
		int n_items;
		sb = new();
		idle_on = 1'b1;
		hold_left = 0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		in_valid = 1'b0;
		func = FN_INIT;
		task_index = '0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// No slots in use yet: everything reports an empty status.
		send_item(FN_SPARE6, 3'd7);
		send_item(FN_TICK, 3'd0);
		send_item(FN_DISPATCH, 3'd0);
		send_item(FN_TRIGGER, 3'd0);
		settle();

		// Mixed periods, a tie at priority zero and never-run slots.
		write_cfg(CFG_TASK_COUNT, 64'd8);
		write_cfg(CFG_PERIODS_LOW, 64'h0004_0003_0002_0001);
		write_cfg(CFG_PERIODS_HIGH, 64'hFFFF_0000_0002_0001);
		write_cfg(CFG_PRIORITIES, 64'hFF05_0500_0900_03FF);
		// Tick before init wraps the zero countdowns.
		send_item(FN_TICK, 3'd0);
		send_item(FN_INIT, 3'd0);
		send_item(FN_DISPATCH, 3'd0);
		send_item(FN_FINISH, 3'd0);
		send_item(FN_TICK, 3'd0);
		send_item(FN_TICK, 3'd0);
		send_item(FN_DISPATCH, 3'd0);
		// Refused dispatch, then triggering the running slot.
		send_item(FN_DISPATCH, 3'd0);
		send_item(FN_TRIGGER, 3'd4);
		send_item(FN_TICK, 3'd0);
		send_item(FN_TRIGGER, 3'd2);
		send_item(FN_FINISH, 3'd0);
		send_item(FN_DISPATCH, 3'd0);
		send_item(FN_SPARE7, 3'd5);
		send_item(FN_CLEAR, 3'd0);
		send_item(FN_FINISH, 3'd0);
		settle();

		// Oversized slot count behaves as a full set of slots.
		write_cfg(CFG_TASK_COUNT, 64'd15);
		send_item(FN_TICK, 3'd0);
		send_item(FN_TRIGGER, 3'd7);
		send_item(FN_DISPATCH, 3'd0);
		settle();

		// Trigger beyond the slots in use is ignored.
		write_cfg(CFG_TASK_COUNT, 64'd3);
		send_item(FN_TRIGGER, 3'd5);
		send_item(FN_TICK, 3'd0);
		send_item(FN_CLEAR, 3'd0);
		settle();

		// Random phases, each with its own configuration.
		for (int ph = 0; ph < 8; ph++) begin
			case (ph)
				0: cnt = 4'd8;
				1: cnt = 4'd0;
				2: cnt = 4'd1;
				3: cnt = 4'd15;
				7: cnt = 4'($urandom_range(0, 15));
				default: cnt = 4'($urandom_range(1, 8));
			endcase
			for (int i = 0; i < 4; i++) begin
				plo[16*i +: 16] = rand_period();
				phi[16*i +: 16] = rand_period();
			end
			for (int i = 0; i < MAX_TASKS; i++)
				prw[8*i +: 8] = rand_prio();
			// Upper bits of the slot count write carry noise.
			write_cfg(CFG_TASK_COUNT, {$urandom, 28'($urandom_range(0, 268435455)), cnt});
			write_cfg(CFG_PERIODS_LOW, plo);
			write_cfg(CFG_PERIODS_HIGH, phi);
			write_cfg(CFG_PRIORITIES, prw);
			n_items = (cnt == 4'd0) ? 40 : 210;
			send_item(FN_INIT, 3'($urandom_range(0, 7)));
			for (int k = 0; k < n_items; k++) begin
				// Long result hold-off so that the block backs up and stalls its input.
				if (ph == 4 && k == 20)
					hold_left = HOLD_CYCLES;
				send_item(rand_func(), 3'($urandom_range(0, 7)));
			end
			settle();
		end

		// Final stretch without idling: every slot expires on each tick and overruns from the second tick on.
		idle_on = 1'b0;
		write_cfg(CFG_TASK_COUNT, 64'd8);
		write_cfg(CFG_PERIODS_LOW, 64'h0001_0001_0001_0001);
		write_cfg(CFG_PERIODS_HIGH, 64'h0001_0001_0001_0001);
		write_cfg(CFG_PRIORITIES, 64'h00FF_FFFF_FFFF_FFFF);
		send_item(FN_INIT, 3'd0);
		for (int k = 0; k < FINAL_TICKS; k++)
			send_item(FN_TICK, 3'($urandom_range(0, 7)));
		send_item(FN_DISPATCH, 3'd0);
		send_item(FN_TICK, 3'd0);
		send_item(FN_FINISH, 3'd0);
		send_item(FN_CLEAR, 3'd0);
		send_item(FN_TICK, 3'd0);
		settle();

		if (sb.fails == 0)
			$display("priority_periodic_task_scheduler_core test passed");
		else
			$display("priority_periodic_task_scheduler_core test failed");
		$finish;
	end

endmodule

>>> filelist.f
+incdir+src
src/pts_pkg.sv
src/pts_ctrl.sv
src/pts_datapath.sv
src/priority_periodic_task_scheduler_core.sv
tb/sv/tb_priority_periodic_task_scheduler_core.sv
